[src/bao_pkg.sv]
package bao_pkg;

   localparam int MAX_STEPS = 256;
   localparam int DEPTH     = MAX_STEPS + 1;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int PRICE_W   = 48;
   localparam int VAL_W     = 32;
   localparam int FAC_W     = 32;

   localparam logic [PRICE_W-1:0] PRICE_CAP = {PRICE_W{1'b1}};
   localparam logic [31:0]        PROB_ONE  = 32'h8000_0000;

   localparam logic [2:0] REG_STEPS    = 3'd0;
   localparam logic [2:0] REG_UP       = 3'd1;
   localparam logic [2:0] REG_DOWN     = 3'd2;
   localparam logic [2:0] REG_PROB     = 3'd3;
   localparam logic [2:0] REG_STEP_DSC = 3'd4;
   localparam logic [2:0] REG_MODE     = 3'd5;
   localparam logic [2:0] REG_FWD      = 3'd6;
   localparam logic [2:0] REG_TOT_DSC  = 3'd7;

   localparam logic [1:0] MODE_EXPIRY = 2'd1;
   localparam logic [1:0] MODE_ZVOL   = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_Z2A, S_Z2B, S_ROW, S_TERM, S_TADV1, S_TADV2, S_BROW, S_BLOAD,
      S_MIX1, S_MIX2, S_MIX3, S_CONT1, S_CONT2, S_BADV1, S_BADV2, S_FIN, S_FIN2, S_OUT
   } state_type;

   typedef enum logic [1:0] {MF_IDLE, MF_LO, MF_HI, MF_FIN} mf_state_type;

   typedef struct packed {
      logic               start;
      logic [PRICE_W-1:0] a;
      logic [FAC_W-1:0]   f;
   } mf_req_type;

   typedef struct packed {
      logic               done;
      logic [PRICE_W-1:0] r;
   } mf_rsp_type;

   function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] price,
                                                 input logic [31:0] strike,
                                                 input logic put);
      logic [PRICE_W-1:0] k;
      k = {strike, 16'b0};
      if (put) begin
         return (k > price) ? k - price : '0;
      end
      return (price > k) ? price - k : '0;
   endfunction

   function automatic logic [VAL_W-1:0] to_value(input logic [PRICE_W-1:0] q);
      logic [PRICE_W:0] s;
      logic [PRICE_W-16:0] v;
      s = {1'b0, q} + (PRICE_W+1)'(32'h8000);
      v = s[PRICE_W:16];
      return v[PRICE_W-16] ? {VAL_W{1'b1}} : v[VAL_W-1:0];
   endfunction

endpackage

[src/bao_mulf.sv]
module bao_mulf (
   input  logic                clock,
   input  logic                reset,
   input  bao_pkg::mf_req_type req,
   output bao_pkg::mf_rsp_type rsp
);
   import bao_pkg::*;

   mf_state_type            state_ff, state_in;
   logic [PRICE_W-1:0]      a_ff, a_in;
   logic [FAC_W-1:0]        f_ff, f_in;
   logic [63:0]             lo_ff, lo_in;
   logic [47:0]             hi_ff, hi_in;
   logic [PRICE_W-1:0]      r_ff, r_in;
   logic                    done_ff, done_in;
   logic [64:0]             lo_rnd;
   logic [50:0]             sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MF_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff  <= a_in;
      f_ff  <= f_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      r_ff  <= r_in;
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      f_in     = f_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      r_in     = r_ff;
      done_in  = 1'b0;
      lo_rnd   = {1'b0, lo_ff} + 65'(32'h2000_0000);
      sum      = {hi_ff, 2'b0} + 51'(lo_rnd[64:30]);
      case (state_ff)
         MF_IDLE: begin
            if (req.start) begin
               a_in     = req.a;
               f_in     = req.f;
               state_in = MF_LO;
            end
         end
         MF_LO: begin
            lo_in    = 64'(a_ff[31:0]) * 64'(f_ff);
            state_in = MF_HI;
         end
         MF_HI: begin
            hi_in    = 48'(a_ff[PRICE_W-1:32]) * 48'(f_ff);
            state_in = MF_FIN;
         end
         MF_FIN: begin
            r_in     = (sum > 51'(PRICE_CAP)) ? PRICE_CAP : sum[PRICE_W-1:0];
            done_in  = 1'b1;
            state_in = MF_IDLE;
         end
         default: state_in = MF_IDLE;
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.r    = r_ff;

endmodule

[src/binomial_american_option_pricer_top.sv]
// American option pricer on a Cox-Ross-Rubinstein lattice. Write the lattice factors over the
// csr port while idle, then send spot and strike (Q16.16) with the put flag on req_tuser; one
// item comes back with the value (Q16.16, saturating) and the status on rsp_tuser. Lattice mode
// keeps the row start prices and the node values in two on-chip memories and walks the lattice
// with a single shared 32x32 multiplier and a two-pass price multiplier: it writes the row
// start prices, then the terminal payoffs, then walks the interior nodes back to the root.
// Zero-expiry, zero-volatility and unstable items skip the lattice. A new item is taken
// while a result still waits.
module binomial_american_option_pricer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // spot_price, strike_price
   input  logic        req_tuser,   // is_put
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // option_value
   output logic        rsp_tuser,   // status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bao_pkg::*;

   // configuration registers
   logic [8:0]  steps_ff;
   logic [31:0] up_ff, down_ff, prob_ff, sdisc_ff, fwd_ff, tdisc_ff;
   logic [1:0]  mode_ff;
   logic [2:0]  reg_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 9'd1;
         up_ff    <= 32'h4000_0000;
         down_ff  <= 32'h4000_0000;
         prob_ff  <= 32'h4000_0000;
         sdisc_ff <= 32'h4000_0000;
         mode_ff  <= 2'd0;
         fwd_ff   <= 32'h4000_0000;
         tdisc_ff <= 32'h4000_0000;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_STEPS:    steps_ff <= csr_pwdata[8:0];
            REG_UP:       up_ff    <= csr_pwdata;
            REG_DOWN:     down_ff  <= csr_pwdata;
            REG_PROB:     prob_ff  <= csr_pwdata;
            REG_STEP_DSC: sdisc_ff <= csr_pwdata;
            REG_MODE:     mode_ff  <= csr_pwdata[1:0];
            REG_FWD:      fwd_ff   <= csr_pwdata;
            REG_TOT_DSC:  tdisc_ff <= csr_pwdata;
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_STEPS:    csr_prdata = {23'b0, steps_ff};
         REG_UP:       csr_prdata = up_ff;
         REG_DOWN:     csr_prdata = down_ff;
         REG_PROB:     csr_prdata = prob_ff;
         REG_STEP_DSC: csr_prdata = sdisc_ff;
         REG_MODE:     csr_prdata = {30'b0, mode_ff};
         REG_FWD:      csr_prdata = fwd_ff;
         REG_TOT_DSC:  csr_prdata = tdisc_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // memories
   logic [PRICE_W-1:0] row_mem [DEPTH];
   logic [VAL_W-1:0]   node_mem [DEPTH];
   logic               row_we, node_we;
   logic [ADDR_W-1:0]  row_wa, row_ra, node_wa, node_ra;
   logic [PRICE_W-1:0] row_wd, row_rd_ff;
   logic [VAL_W-1:0]   node_wd, node_rd_ff;

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      row_rd_ff <= row_mem[row_ra];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[node_ra];
   end

   // price multiplier
   mf_req_type mf_req;
   mf_rsp_type mf_rsp;

   bao_mulf u_mulf (
      .clock (clock),
      .reset (reset),
      .req   (mf_req),
      .rsp   (mf_rsp)
   );

   // sequencer
   state_type          state_ff, state_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [31:0]        strike_ff, strike_in;
   logic               put_ff, put_in;
   logic [VAL_W-1:0]   intr_ff, intr_in, result_ff, result_in;
   logic               status_ff, status_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [8:0]         n_ff, n_in, cnt_ff, cnt_in, step_ff, step_in;
   logic [VAL_W-1:0]   vj_ff, vj_in, vj1_ff, vj1_in, mix_ff, mix_in;
   logic [63:0]        prod_ff, prod_in, acc_ff, acc_in;
   logic [31:0]        mul_x, mul_y, q_prob;
   logic               mul_en, mf_use;
   logic [64:0]        mix_sum, cont_sum;
   logic [34:0]        cont_w;
   logic [VAL_W-1:0]   cont_v, ex_v, eu_v;
   logic [PRICE_W-1:0] spot_w;

   assign q_prob   = PROB_ONE - prob_ff;
   assign spot_w   = {req_tdata[31:0], 16'b0};
   assign mix_sum  = {1'b0, acc_ff} + {1'b0, prod_ff} + 65'(32'h4000_0000);
   assign cont_sum = {1'b0, prod_ff} + 65'(32'h2000_0000);
   assign cont_w   = cont_sum[64:30];
   assign cont_v   = (cont_w[34:32] != 3'b0) ? {VAL_W{1'b1}} : cont_w[31:0];
   assign ex_v     = to_value(payoff(price_ff, strike_ff, put_ff));
   assign eu_v     = to_value(mf_rsp.r);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      strike_ff     <= strike_in;
      put_ff        <= put_in;
      intr_ff       <= intr_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      price_ff      <= price_in;
      n_ff          <= n_in;
      cnt_ff        <= cnt_in;
      step_ff       <= step_in;
      vj_ff         <= vj_in;
      vj1_ff        <= vj1_in;
      mix_ff        <= mix_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      strike_in     = strike_ff;
      put_in        = put_ff;
      intr_in       = intr_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      price_in      = price_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      vj_in         = vj_ff;
      vj1_in        = vj1_ff;
      mix_in        = mix_ff;
      acc_in        = acc_ff;
      mul_x         = prob_ff;
      mul_y         = node_rd_ff;
      mul_en        = 1'b0;
      mf_use        = 1'b0;
      mf_req.a      = price_ff;
      mf_req.f      = up_ff;
      row_we        = 1'b0;
      row_wa        = '0;
      row_wd        = price_ff;
      row_ra        = step_ff[ADDR_W-1:0];
      node_we       = 1'b0;
      node_wa       = cnt_ff[ADDR_W-1:0];
      node_wd       = ex_v;
      node_ra       = cnt_ff[ADDR_W-1:0] + ADDR_W'(1);
      req_tready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               strike_in = req_tdata[63:32];
               put_in    = req_tuser;
               intr_in   = to_value(payoff(spot_w, req_tdata[63:32], req_tuser));
               price_in  = spot_w;
               cnt_in    = 9'd1;
               status_in = 1'b0;
               row_we    = 1'b1;
               row_wd    = spot_w;
               if (steps_ff == 9'd0) begin
                  n_in = 9'd1;
               end else if (steps_ff > 9'(MAX_STEPS)) begin
                  n_in = 9'(MAX_STEPS);
               end else begin
                  n_in = steps_ff;
               end
               if (mode_ff == MODE_EXPIRY) begin
                  result_in = to_value(payoff(spot_w, req_tdata[63:32], req_tuser));
                  state_in  = S_OUT;
               end else if (mode_ff == MODE_ZVOL) begin
                  state_in = S_Z2A;
               end else if (prob_ff == 32'd0 || prob_ff >= PROB_ONE) begin
                  result_in = '0;
                  status_in = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_ROW;
               end
            end
         end
         S_Z2A: begin
            mf_use   = 1'b1;
            mf_req.f = fwd_ff;
            if (mf_rsp.done) begin
               price_in = mf_rsp.r;
               state_in = S_Z2B;
            end
         end
         S_Z2B: begin
            mf_use   = 1'b1;
            mf_req.a = payoff(price_ff, strike_ff, put_ff);
            mf_req.f = tdisc_ff;
            if (mf_rsp.done) begin
               result_in = (eu_v > intr_ff) ? eu_v : intr_ff;
               state_in  = S_OUT;
            end
         end
         S_ROW: begin
            mf_use   = 1'b1;
            mf_req.f = down_ff;
            row_wa   = cnt_ff[ADDR_W-1:0];
            row_wd   = mf_rsp.r;
            if (mf_rsp.done) begin
               price_in = mf_rsp.r;
               row_we   = 1'b1;
               if (cnt_ff == n_ff) begin
                  cnt_in   = '0;
                  state_in = S_TERM;
               end else begin
                  cnt_in = cnt_ff + 9'd1;
               end
            end
         end
         S_TERM: begin
            node_we = 1'b1;
            if (cnt_ff == n_ff) begin
               step_in  = n_ff - 9'd1;
               cnt_in   = '0;
               state_in = S_BROW;
            end else begin
               cnt_in   = cnt_ff + 9'd1;
               state_in = S_TADV1;
            end
         end
         S_TADV1, S_TADV2, S_BADV1, S_BADV2: begin
            mf_use = 1'b1;
            if (mf_rsp.done) begin
               price_in = mf_rsp.r;
               case (state_ff)
                  S_TADV1: state_in = S_TADV2;
                  S_TADV2: state_in = S_TERM;
                  S_BADV1: state_in = S_BADV2;
                  default: state_in = S_MIX1;
               endcase
            end
         end
         S_BROW: begin
            node_ra  = '0;
            state_in = S_BLOAD;
         end
         S_BLOAD: begin
            price_in = row_rd_ff;
            vj_in    = node_rd_ff;
            state_in = S_MIX1;
         end
         S_MIX1: begin
            vj1_in   = node_rd_ff;
            mul_en   = 1'b1;
            state_in = S_MIX2;
         end
         S_MIX2: begin
            acc_in   = prod_ff;
            mul_x    = q_prob;
            mul_y    = vj_ff;
            mul_en   = 1'b1;
            state_in = S_MIX3;
         end
         S_MIX3: begin
            mix_in   = mix_sum[62:31];
            state_in = S_CONT1;
         end
         S_CONT1: begin
            mul_x    = mix_ff;
            mul_y    = sdisc_ff;
            mul_en   = 1'b1;
            state_in = S_CONT2;
         end
         S_CONT2: begin
            node_we = 1'b1;
            node_wd = (ex_v > cont_v) ? ex_v : cont_v;
            if (cnt_ff == step_ff) begin
               if (step_ff == 9'd0) begin
                  state_in = S_FIN;
               end else begin
                  step_in  = step_ff - 9'd1;
                  cnt_in   = '0;
                  state_in = S_BROW;
               end
            end else begin
               vj_in    = vj1_ff;
               cnt_in   = cnt_ff + 9'd1;
               state_in = S_BADV1;
            end
         end
         S_FIN: begin
            node_ra  = '0;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            result_in = node_rd_ff;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = result_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      mf_req.start = mf_use & ~pend_ff;
      if (mf_req.start) begin
         pend_in = 1'b1;
      end else if (mf_rsp.done) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
      prod_in = mul_en ? 64'(mul_x) * 64'(mul_y) : prod_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      mf_rsp.done |-> pend_ff)
      else $error("price multiplier finished with no request pending");

   a_node_addr: assert property (@(posedge clock) disable iff (reset)
      node_we |-> (9'(node_wa) <= n_ff))
      else $error("node write beyond the lattice");

   a_back_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONT2) |-> (cnt_ff <= step_ff && step_ff < n_ff))
      else $error("backward node index out of row");

   a_unstable_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 32'd0))
      else $error("unstable status with nonzero value");

endmodule

[dv/binomial_american_option_pricer_top_tb.sv]
`timescale 1ns / 1ps

module binomial_american_option_pricer_top_tb;
   import bao_pkg::*;

   localparam int STALL_LIMIT = 2000000;

   typedef struct packed {
      logic [31:0] value;
      logic        unstable;
   } quote_type;

   // pricer state kept on the bench side
   logic [8:0]  cfg_steps;
   logic [31:0] cfg_up, cfg_down, cfg_prob, cfg_sdsc, cfg_fwd, cfg_tdsc;
   logic [1:0]  cfg_mode;

   class quote_board;
      quote_type pending[$];
      int        errors;

      function void note_request(quote_type q);
         pending.push_back(q);
      endfunction

      function void check_quote(logic [31:0] value, logic unstable);
         quote_type q;
         if (pending.size() == 0) begin
            $display("%0t unexpected result: expected none, actual value %h status %b",
                     $time, value, unstable);
            errors++;
            return;
         end
         q = pending.pop_front();
         if (q.value !== value) begin
            $display("%0t value mismatch: expected %h, actual %h", $time, q.value, value);
            errors++;
         end
         if (q.unstable !== unstable) begin
            $display("%0t status mismatch: expected %b, actual %b", $time, q.unstable, unstable);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   quote_board board = new();
   bit         calm = 0;
   int         quiet_cycles = 0;

   binomial_american_option_pricer_top dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic logic [47:0] scale(logic [47:0] a, logic [31:0] f);
      logic [95:0] hi, lo, r;
      hi = {48'b0, 16'b0, a[47:32]} * f;
      lo = {64'b0, a[31:0]} * f;
      r = (hi << 2) + ((lo + (96'd1 << 29)) >> 30);
      return (r > {48'b0, PRICE_CAP}) ? PRICE_CAP : r[47:0];
   endfunction

   function automatic logic [47:0] gain(logic [47:0] price, logic [31:0] strike, logic put);
      logic [47:0] k;
      k = {strike, 16'b0};
      if (put) return (k > price) ? k - price : '0;
      return (price > k) ? price - k : '0;
   endfunction

   function automatic logic [31:0] round_value(logic [47:0] q);
      logic [48:0] v;
      v = ({1'b0, q} + 49'h8000) >> 16;
      return (v > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [47:0] start_of_row(logic [31:0] spot, int row);
      logic [47:0] p;
      p = {spot, 16'b0};
      for (int k = 0; k < row; k++) p = scale(p, cfg_down);
      return p;
   endfunction

   function automatic quote_type price_option(logic [31:0] spot, logic [31:0] strike, logic put);
      quote_type   q;
      logic [31:0] nodes[MAX_STEPS+1];
      logic [31:0] intrinsic, euv, ex;
      logic [47:0] price;
      logic [95:0] mix, cont;
      int          n;
      intrinsic = round_value(gain({spot, 16'b0}, strike, put));
      q.unstable = 0;
      if (cfg_mode == MODE_EXPIRY) begin
         q.value = intrinsic;
      end else if (cfg_mode == MODE_ZVOL) begin
         euv = round_value(scale(gain(scale({spot, 16'b0}, cfg_fwd), strike, put), cfg_tdsc));
         q.value = (euv > intrinsic) ? euv : intrinsic;
      end else if (cfg_prob == 0 || cfg_prob >= PROB_ONE) begin
         q.value = 0;
         q.unstable = 1;
      end else begin
         n = cfg_steps;
         if (n == 0) n = 1;
         if (n > MAX_STEPS) n = MAX_STEPS;
         price = start_of_row(spot, n);
         for (int j = 0; j <= n; j++) begin
            if (j > 0) price = scale(scale(price, cfg_up), cfg_up);
            nodes[j] = round_value(gain(price, strike, put));
         end
         for (int s = n - 1; s >= 0; s--) begin
            price = start_of_row(spot, s);
            for (int j = 0; j <= s; j++) begin
               if (j > 0) price = scale(scale(price, cfg_up), cfg_up);
               mix = (96'(cfg_prob) * nodes[j+1] + 96'(PROB_ONE - cfg_prob) * nodes[j]
                      + (96'd1 << 30)) >> 31;
               cont = (mix * cfg_sdsc + (96'd1 << 29)) >> 30;
               if (cont > 96'hFFFF_FFFF) cont = 96'hFFFF_FFFF;
               ex = round_value(gain(price, strike, put));
               nodes[j] = (ex > cont[31:0]) ? ex : cont[31:0];
            end
         end
         q.value = nodes[0];
      end
      return q;
   endfunction

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_STEPS:    cfg_steps = value[8:0];
         REG_UP:       cfg_up = value;
         REG_DOWN:     cfg_down = value;
         REG_PROB:     cfg_prob = value;
         REG_STEP_DSC: cfg_sdsc = value;
         REG_MODE:     cfg_mode = value[1:0];
         REG_FWD:      cfg_fwd = value;
         REG_TOT_DSC:  cfg_tdsc = value;
         default: ;
      endcase
   endtask

   task automatic setup(logic [8:0] steps, logic [31:0] up, logic [31:0] down,
                        logic [31:0] prob, logic [31:0] sdsc, logic [1:0] mode,
                        logic [31:0] fwd, logic [31:0] tdsc);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      write_reg(REG_STEPS, steps);
      write_reg(REG_UP, up);
      write_reg(REG_DOWN, down);
      write_reg(REG_PROB, prob);
      write_reg(REG_STEP_DSC, sdsc);
      write_reg(REG_MODE, mode);
      write_reg(REG_FWD, fwd);
      write_reg(REG_TOT_DSC, tdsc);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic send(logic [31:0] spot, logic [31:0] strike, logic put);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {strike, spot};
      req_tuser <= put;
      do @(posedge clock); while (!req_tready);
      board.note_request(price_option(spot, strike, put));
   endtask

   function automatic logic [31:0] rand_price();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(32'h0010_0000, 32'h0100_0000);
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_quote(rsp_tdata, rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (burst > 0) begin
            burst--;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 8) - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   initial begin
      logic [31:0] ups[4] = '{32'h4400_0000, 32'h4CCC_CCCD, 32'h4080_0000, 32'h6000_0000};
      logic [31:0] up, down;
      cfg_steps = 1; cfg_up = 32'h4000_0000; cfg_down = 32'h4000_0000;
      cfg_prob = 32'h4000_0000; cfg_sdsc = 32'h4000_0000; cfg_mode = 0;
      cfg_fwd = 32'h4000_0000; cfg_tdsc = 32'h4000_0000;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset defaults
      send(32'h0064_0000, 32'h005A_0000, 0);
      send(32'h0064_0000, 32'h0070_0000, 1);
      // small lattice with real factors
      setup(4, 32'h4400_0000, 32'h3C3C_3C3C, 32'h4200_0000, 32'h3FF0_0000, 0,
            32'h4100_0000, 32'h3F00_0000);
      send(32'h0064_0000, 32'h0064_0000, 0);
      send(32'h0064_0000, 32'h0064_0000, 1);
      send(0, 32'hFFFF_FFFF, 1);
      send(32'hFFFF_FFFF, 0, 0);
      send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      // unstable probability
      setup(3, 32'h4400_0000, 32'h3C3C_3C3C, 0, 32'h4000_0000, 0, 32'h4000_0000, 32'h4000_0000);
      send(32'h0064_0000, 32'h0050_0000, 0);
      setup(3, 32'h4400_0000, 32'h3C3C_3C3C, PROB_ONE, 32'h4000_0000, 3,
            32'h4000_0000, 32'h4000_0000);
      send(32'h0064_0000, 32'h0050_0000, 1);
      setup(3, 32'h4400_0000, 32'h3C3C_3C3C, 32'hFFFF_FFFF, 32'h4000_0000, 0,
            32'h4000_0000, 32'h4000_0000);
      send(32'h0064_0000, 32'h0050_0000, 0);
      // zero expiry, with unstable probability ignored
      setup(0, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, MODE_EXPIRY, 0, 0);
      send(32'h0064_0000, 32'h0050_0000, 0);
      send(32'h0064_0000, 32'h0050_0000, 1);
      send(32'hFFFF_FFFF, 0, 0);
      // zero volatility
      setup(2, 32'h4000_0000, 32'h4000_0000, PROB_ONE, 32'h4000_0000, MODE_ZVOL,
            32'h4400_0000, 32'h3C3C_3C3C);
      send(32'h0064_0000, 32'h0064_0000, 0);
      send(32'h0064_0000, 32'h0070_0000, 1);
      setup(2, 32'h4000_0000, 32'h4000_0000, 1, 32'h4000_0000, MODE_ZVOL,
            32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(32'hFFFF_FFFF, 0, 0);
      send(32'h0001_0000, 32'hFFFF_FFFF, 1);
      // step count zero, above maximum, extreme factors and probabilities
      setup(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0, 0);
      send(32'hFFFF_FFFF, 32'h0000_0001, 0);
      send(32'h0000_0001, 32'hFFFF_FFFF, 1);
      setup(9'h1FF, 32'h4080_0000, 32'h3F80_0000, 32'h7FFF_FFFF, 32'h3FFF_0000, 0,
            32'h4000_0000, 32'h4000_0000);
      send(32'h0064_0000, 32'h0064_0000, 1);
      setup(MAX_STEPS, 0, 0, 32'h4000_0000, 0, 0, 32'h4000_0000, 32'h4000_0000);
      send(32'h0064_0000, 32'h0064_0000, 1);

      // random phases, mostly small lattices
      for (int ph = 0; ph < 12; ph++) begin
         up = ups[$urandom_range(0, 3)];
         down = $urandom_range(0, 1) ? 32'h3C3C_3C3C : $urandom();
         setup((ph == 5) ? 9'd200 : 9'($urandom_range(1, 12)), up, down,
               ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1, 32'h7FFF_FFFF),
               $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(32'h3F00_0000,
               32'h4000_0000), 2'($urandom_range(0, 3)), $urandom(), $urandom());
         if (ph >= 9) calm = 1;
         for (int i = 0; i < ((ph == 5) ? 1 : 9); i++)
            send(rand_price(), rand_price(), 1'($urandom_range(0, 1)));
      end

      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
src/bao_pkg.sv
src/bao_mulf.sv
src/binomial_american_option_pricer_top.sv
dv/binomial_american_option_pricer_top_tb.sv
